// ===== hw/rtl/weighted_random_picker_unit_macros.svh =====
// assertion macros for the weighted random picker
`ifndef WEIGHTED_RANDOM_PICKER_UNIT_MACROS_SVH
`define WEIGHTED_RANDOM_PICKER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define WRP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition must never be seen outside reset
`define WRP_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define WRP_ASSERT(lbl, clk, rstn, prop, msg)
`define WRP_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== hw/rtl/wrp_pkg.sv =====
// shared types and constants of the weighted random picker
package wrp_pkg;

  localparam int unsigned CFG_W      = 10;
  localparam int unsigned WEIGHT_W   = 32;
  localparam int unsigned TOTAL_W    = 41;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned DRAW_W     = 16;
  localparam int unsigned IDX_IN_W   = 9;
  localparam int unsigned SUM_W      = CFG_W + WEIGHT_W;
  localparam int unsigned NEWW_W     = 2 * WEIGHT_W - FRAC_W;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [CFG_W-1:0] CFG_ENTRIES_RESET = 10'd512;

  // register index taken from paddr[2]
  localparam logic REG_ENTRIES_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_SCALE = 2'd1,
    KIND_PUNCH = 2'd2,
    KIND_PICK  = 2'd3
  } kind_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic upd_read;
    logic upd_calc;
    logic upd_write;
    logic scan_start;
    logic scan;
    logic load_result;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic idx_ok;
    logic total_zero;
    logic scan_hit;
    logic scan_end;
    logic slot_free;
  } sts_t;

endpackage

// ===== hw/rtl/weighted_random_picker_unit.sv =====
// top level of the weighted random picker: config register, controller, datapath
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o  kind_i, entry_index_i, amount_i, random_draw_i
//   out      source     out_valid_o / out_stall_i picked_entry_o, no_pick_o
//   cfg      apb slave  psel, penable, pwrite    paddr, pwdata, prdata, pready
//
// after reset the weight store is zeroed one entry a cycle, all ENTRIES, input stalled
// an update steps through the read, calc and write states; an update on an index out
// of range is taken and dropped; a pick computes the threshold and, unless the total
// is zero, scans the entries in use until one is hit or the end is passed; the scan
// reads one entry a cycle from the single read port of the weight store
// a finished pick waits in the output register; the input is taken again meanwhile,
// a second pick then holds in its last cycle until the output register frees up

`include "weighted_random_picker_unit_macros.svh"

module weighted_random_picker_unit #(
  parameter int unsigned ENTRIES = 512
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // item input
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           kind_i,
  input  logic [wrp_pkg::IDX_IN_W-1:0]         entry_index_i,
  input  logic [wrp_pkg::WEIGHT_W-1:0]         amount_i,
  input  logic [wrp_pkg::DRAW_W-1:0]           random_draw_i,
  // result output
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [wrp_pkg::IDX_IN_W-1:0]         picked_entry_o,
  output logic                                 no_pick_o,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [wrp_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [wrp_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [wrp_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  logic [wrp_pkg::CFG_W-1:0] entries_q;
  logic                      reg_sel;
  wrp_pkg::cmd_t             cmd;
  wrp_pkg::sts_t             sts;

  // register file: one register, index in paddr[2], byte offset ignored
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == wrp_pkg::REG_ENTRIES_IN_USE);
  assign prdata  = reg_sel ? wrp_pkg::APB_DATA_W'(entries_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= wrp_pkg::CFG_ENTRIES_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      entries_q <= pwdata[wrp_pkg::CFG_W-1:0];
    end
  end

  // sequencer
  wrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // store, total, scan and result register
  wrp_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .entries_in_use_i (entries_q),
    .kind_i           (kind_i),
    .entry_index_i    (entry_index_i),
    .amount_i         (amount_i),
    .random_draw_i    (random_draw_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .picked_entry_o   (picked_entry_o),
    .no_pick_o        (no_pick_o)
  );

  // terms for the checks below
  logic hit_valid, hit_in_range, load_over, tot_zero, upd_wr;

  assign hit_valid    = out_valid_o && !no_pick_o;
  assign hit_in_range = (int'(picked_entry_o) < int'(entries_q))
                     && (int'(picked_entry_o) < ENTRIES);
  assign load_over    = cmd.load_result && out_valid_o && out_stall_i;
  assign tot_zero     = sts.total_zero;
  assign upd_wr       = cmd.upd_write;

  // a hit always lies inside the entries in use
  `WRP_ASSERT(a_pick_in_range, clk_i, rst_ni, hit_valid |-> hit_in_range, "pick out of range")

  // a new result never overwrites one still waiting
  `WRP_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, load_over, "result loaded over a stalled beat")

  // the total moves only on an update write
  `WRP_ASSERT(a_total_on_write, clk_i, rst_ni, !$stable(tot_zero) |-> $past(upd_wr), "total moved")

endmodule

// ===== hw/rtl/wrp_ctrl.sv =====
// sequencing state machine of the weighted random picker
module wrp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    kind_i,
  output logic          in_stall_o,
  input  wrp_pkg::sts_t sts_i,
  output wrp_pkg::cmd_t cmd_o
);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_UPD_RD = 8'b0000_0100,
    ST_UPD_MU = 8'b0000_1000,
    ST_UPD_WR = 8'b0001_0000,
    ST_PK_MUL = 8'b0010_0000,
    ST_PK_SCN = 8'b0100_0000,
    ST_PK_DON = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  wrp_pkg::kind_e kind;

  assign kind       = wrp_pkg::kind_e'(kind_i);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (kind == wrp_pkg::KIND_PICK) begin
            state_d = ST_PK_MUL;
          end else if (sts_i.idx_ok) begin
            state_d = ST_UPD_RD;
          end
        end
      end
      ST_UPD_RD: begin
        cmd_o.upd_read = 1'b1;
        state_d        = ST_UPD_MU;
      end
      ST_UPD_MU: begin
        cmd_o.upd_calc = 1'b1;
        state_d        = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        cmd_o.upd_write = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_PK_MUL: begin
        cmd_o.scan_start = 1'b1;
        state_d          = sts_i.total_zero ? ST_PK_DON : ST_PK_SCN;
      end
      ST_PK_SCN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_hit || sts_i.scan_end) state_d = ST_PK_DON;
      end
      ST_PK_DON: begin
        if (sts_i.slot_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/wrp_datapath.sv =====
// weight store, running total, scan accumulator and result register
module wrp_datapath #(
  parameter int unsigned ENTRIES = 512,
  localparam int unsigned IDX_W  = $clog2(ENTRIES),
  localparam int unsigned CNT_W  = (IDX_W + 1 > wrp_pkg::CFG_W) ? IDX_W + 1 : wrp_pkg::CFG_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [wrp_pkg::CFG_W-1:0]      entries_in_use_i,
  input  logic [1:0]                     kind_i,
  input  logic [wrp_pkg::IDX_IN_W-1:0]   entry_index_i,
  input  logic [wrp_pkg::WEIGHT_W-1:0]   amount_i,
  input  logic [wrp_pkg::DRAW_W-1:0]     random_draw_i,
  input  wrp_pkg::cmd_t                  cmd_i,
  output wrp_pkg::sts_t                  sts_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [wrp_pkg::IDX_IN_W-1:0]   picked_entry_o,
  output logic                           no_pick_o
);

  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);
  localparam logic [CNT_W-1:0] LAST_C    = CNT_W'(ENTRIES - 1);
  localparam logic [wrp_pkg::WEIGHT_W-1:0] WEIGHT_MAX = '1;

  logic [wrp_pkg::WEIGHT_W-1:0] mem_q [ENTRIES];
  logic [wrp_pkg::WEIGHT_W-1:0] rdata_q;

  logic [CNT_W-1:0] n_cnt, in_idx_ext, op_idx_ext;
  logic [CNT_W-1:0] clr_q, rd_cnt_q, ridx_q, found_idx_q;
  logic             rv_q, found_q;

  wrp_pkg::kind_e                 op_kind_q;
  logic [wrp_pkg::IDX_IN_W-1:0]   op_idx_q;
  logic [wrp_pkg::WEIGHT_W-1:0]   op_amount_q;
  logic [wrp_pkg::DRAW_W-1:0]     op_draw_q;

  logic [wrp_pkg::TOTAL_W-1:0]    total_q, threshold_q;
  logic [wrp_pkg::SUM_W-1:0]      sum_q, sum_next;
  logic [wrp_pkg::NEWW_W-1:0]     new_q;
  logic [wrp_pkg::WEIGHT_W-1:0]   old_q, new_sat;
  logic [wrp_pkg::TOTAL_W+wrp_pkg::DRAW_W-1:0] thr_prod;
  logic [2*wrp_pkg::WEIGHT_W-1:0] scale_prod;
  logic [wrp_pkg::WEIGHT_W:0]     add_sum;

  logic                 more, we, re;
  logic [IDX_W-1:0]     waddr, raddr;
  logic [wrp_pkg::WEIGHT_W-1:0] wdata;

  logic                          out_valid_q, no_pick_q;
  logic [wrp_pkg::IDX_IN_W-1:0]  picked_q;

  // effective entry count
  assign n_cnt = (CNT_W'(entries_in_use_i) < ENTRIES_C) ? CNT_W'(entries_in_use_i) : ENTRIES_C;

  assign in_idx_ext = CNT_W'(entry_index_i);
  assign op_idx_ext = CNT_W'(op_idx_q);
  assign more       = rd_cnt_q < n_cnt;

  assign sum_next   = sum_q + wrp_pkg::SUM_W'(rdata_q);
  assign thr_prod   = (wrp_pkg::TOTAL_W+wrp_pkg::DRAW_W)'(op_draw_q)
                    * (wrp_pkg::TOTAL_W+wrp_pkg::DRAW_W)'(total_q);
  assign scale_prod = (2*wrp_pkg::WEIGHT_W)'(rdata_q) * (2*wrp_pkg::WEIGHT_W)'(op_amount_q);
  assign add_sum    = {1'b0, rdata_q} + {1'b0, op_amount_q};
  assign new_sat    = (|new_q[wrp_pkg::NEWW_W-1:wrp_pkg::WEIGHT_W]) ? WEIGHT_MAX
                                                                    : new_q[wrp_pkg::WEIGHT_W-1:0];

  // memory port selection
  assign we    = cmd_i.clear | cmd_i.upd_write;
  assign waddr = cmd_i.clear ? clr_q[IDX_W-1:0] : op_idx_ext[IDX_W-1:0];
  assign wdata = cmd_i.clear ? '0 : new_sat;
  assign re    = cmd_i.upd_read | (cmd_i.scan & more);
  assign raddr = cmd_i.scan ? rd_cnt_q[IDX_W-1:0] : op_idx_ext[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  assign sts_o.clear_last = (clr_q == LAST_C);
  assign sts_o.idx_ok     = in_idx_ext < n_cnt;
  assign sts_o.total_zero = (total_q == '0);
  assign sts_o.scan_hit   = rv_q && (wrp_pkg::SUM_W'(threshold_q) < sum_next);
  assign sts_o.scan_end   = !rv_q && !more;
  assign sts_o.slot_free  = !out_valid_q || !out_stall_i;

  // operand and arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_kind_q   <= wrp_pkg::kind_e'(kind_i);
      op_idx_q    <= entry_index_i;
      op_amount_q <= amount_i;
      op_draw_q   <= random_draw_i;
    end
    if (cmd_i.upd_calc) begin
      old_q <= rdata_q;
      case (op_kind_q)
        wrp_pkg::KIND_ADD:   new_q <= wrp_pkg::NEWW_W'(add_sum);
        wrp_pkg::KIND_SCALE: new_q <= scale_prod[2*wrp_pkg::WEIGHT_W-1:wrp_pkg::FRAC_W];
        default:             new_q <= '0;
      endcase
    end
    if (cmd_i.scan_start) begin
      threshold_q <= thr_prod[wrp_pkg::TOTAL_W+wrp_pkg::DRAW_W-1:wrp_pkg::FRAC_W];
      sum_q       <= '0;
      found_q     <= 1'b0;
    end else if (cmd_i.scan && rv_q) begin
      sum_q <= sum_next;
      if (sts_o.scan_hit) begin
        found_q     <= 1'b1;
        found_idx_q <= ridx_q;
      end
    end
    if (cmd_i.scan && more) ridx_q <= rd_cnt_q;
    if (cmd_i.load_result) begin
      no_pick_q <= !found_q;
      picked_q  <= found_q ? found_idx_q[wrp_pkg::IDX_IN_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      rd_cnt_q    <= '0;
      rv_q        <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + 1'b1;
      if (cmd_i.scan_start) begin
        rd_cnt_q <= '0;
        rv_q     <= 1'b0;
      end else if (cmd_i.scan) begin
        rv_q <= more;
        if (more) rd_cnt_q <= rd_cnt_q + 1'b1;
      end
      if (cmd_i.upd_write) begin
        total_q <= total_q - wrp_pkg::TOTAL_W'(old_q) + wrp_pkg::TOTAL_W'(new_sat);
      end
      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign picked_entry_o = picked_q;
  assign no_pick_o      = no_pick_q;

endmodule

// ===== verif/tb_weighted_random_picker_unit.sv =====
// self-checking testbench for the weighted random picker: directed and random beats
`timescale 1ns / 1ps

module tb_weighted_random_picker_unit;

  localparam int unsigned ENTRIES = 512;
  // slowest legal run stays far below this, even with every pick scanning all entries
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  // cycles allowed for an update beat to finish after the last result has come
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam logic [wrp_pkg::WEIGHT_W-1:0] WEIGHT_SAT = '1;

  // byte addresses on the config port, register index sits in paddr[2]
  localparam logic [wrp_pkg::CFG_ADDR_W-1:0] ADDR_ENTRIES = {wrp_pkg::REG_ENTRIES_IN_USE, 2'b00};
  localparam logic [wrp_pkg::CFG_ADDR_W-1:0] ADDR_SPARE   = {~wrp_pkg::REG_ENTRIES_IN_USE, 2'b00};

  // one operation beat on the input channel
  typedef struct packed {
    wrp_pkg::kind_e                kind;
    logic [wrp_pkg::IDX_IN_W-1:0]  idx;
    logic [wrp_pkg::WEIGHT_W-1:0]  amount;
    logic [wrp_pkg::DRAW_W-1:0]    draw;
  } wheel_op_t;

  // one pick result on the output channel
  typedef struct packed {
    logic [wrp_pkg::IDX_IN_W-1:0] entry;
    logic                         missed;
  } pick_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic      in_valid = 1'b0;
  logic      in_stall;
  wheel_op_t op_beat  = '0;

  // output channel
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [wrp_pkg::IDX_IN_W-1:0] picked_entry;
  logic                         no_pick;

  // config port
  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [wrp_pkg::CFG_ADDR_W-1:0] paddr   = '0;
  logic [wrp_pkg::APB_DATA_W-1:0] pwdata  = '0;
  logic [wrp_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  // shadow of the block's weight table, running total and entry count
  logic [wrp_pkg::WEIGHT_W-1:0] weight_table [ENTRIES];
  logic [wrp_pkg::TOTAL_W-1:0]  weight_sum;
  logic [wrp_pkg::CFG_W-1:0]    cfg_entries;

  wheel_op_t op_q[$];     // beats not yet presented
  pick_t     pick_q[$];   // picks accepted, result still owed

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  // set for the closing phase: no idling on either side
  bit          calm = 1'b0;

  weighted_random_picker_unit #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (op_beat.kind),
    .entry_index_i  (op_beat.idx),
    .amount_i       (op_beat.amount),
    .random_draw_i  (op_beat.draw),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .picked_entry_o (picked_entry),
    .no_pick_o      (no_pick),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // entries taking part in updates and picks; counts above the table size clamp
  function automatic int unsigned live_entries();
    return (cfg_entries < ENTRIES) ? cfg_entries : ENTRIES;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // apply one accepted beat to the shadow table; a pick queues its expected result
  function automatic void roll_wheel(input wheel_op_t op);
    pick_t            res;
    logic [63:0]      threshold;
    logic [63:0]      running;
    logic [63:0]      neww;
    int unsigned      n;
    n = live_entries();
    if (op.kind == wrp_pkg::KIND_PICK) begin
      res.entry  = '0;
      res.missed = 1'b1;
      if (weight_sum != '0) begin
        // threshold is the draw taken as a 16-bit fraction of the total
        threshold = (64'(op.draw) * 64'(weight_sum)) >> wrp_pkg::FRAC_W;
        running   = '0;
        for (int c = 0; c < n; c++) begin
          running += 64'(weight_table[c]);
          if (threshold < running) begin
            res.entry  = wrp_pkg::IDX_IN_W'(c);
            res.missed = 1'b0;
            break;
          end
        end
      end
      pick_q.push_back(res);
    end else if (op.idx < n) begin
      case (op.kind)
        wrp_pkg::KIND_ADD: begin
          neww = 64'(weight_table[op.idx]) + 64'(op.amount);
        end
        wrp_pkg::KIND_SCALE: begin
          // Q16.16 product, truncated
          neww = (64'(weight_table[op.idx]) * 64'(op.amount)) >> wrp_pkg::FRAC_W;
        end
        default: begin
          neww = '0;
        end
      endcase
      if (neww > 64'(WEIGHT_SAT)) neww = 64'(WEIGHT_SAT);
      // total moves by exactly the change of this one weight
      weight_sum = weight_sum - wrp_pkg::TOTAL_W'(weight_table[op.idx])
                 + wrp_pkg::TOTAL_W'(neww);
      weight_table[op.idx] = neww[wrp_pkg::WEIGHT_W-1:0];
    end
  endfunction

  // random beat for a phase with n live entries
  function automatic wheel_op_t random_op(input int unsigned n);
    wheel_op_t   op;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) op.kind = wrp_pkg::KIND_ADD;
    else if (roll < 50) op.kind = wrp_pkg::KIND_SCALE;
    else if (roll < 60) op.kind = wrp_pkg::KIND_PUNCH;
    else op.kind = wrp_pkg::KIND_PICK;
    // mostly live indices so updates land; the rest covers out of range and all index bits
    if (n != 0 && $urandom_range(0, 99) < 85) begin
      op.idx = wrp_pkg::IDX_IN_W'($urandom_range(0, n - 1));
    end else begin
      op.idx = wrp_pkg::IDX_IN_W'($urandom());
    end
    roll = $urandom_range(0, 9);
    case (op.kind)
      wrp_pkg::KIND_ADD: begin
        if (roll == 0) op.amount = '0;
        else if (roll <= 5) op.amount = $urandom_range(1, 32'h0004_0000);
        else if (roll <= 7) op.amount = $urandom();
        else op.amount = {16'hFFFF, 16'($urandom())};
      end
      wrp_pkg::KIND_SCALE: begin
        if (roll == 0) op.amount = '0;
        else if (roll == 1) op.amount = '1;
        else if (roll == 2) op.amount = $urandom();
        else op.amount = $urandom_range(32'h0000_8000, 32'h0002_0000);
      end
      default: begin
        op.amount = $urandom();
      end
    endcase
    roll = $urandom_range(0, 9);
    if (roll == 0) op.draw = '0;
    else if (roll == 1) op.draw = '1;
    else op.draw = wrp_pkg::DRAW_W'($urandom());
    return op;
  endfunction

  function automatic void queue_op(input wrp_pkg::kind_e kind,
                                   input logic [wrp_pkg::IDX_IN_W-1:0] idx,
                                   input logic [wrp_pkg::WEIGHT_W-1:0] amount,
                                   input logic [wrp_pkg::DRAW_W-1:0] draw);
    wheel_op_t op;
    op.kind   = kind;
    op.idx    = idx;
    op.amount = amount;
    op.draw   = draw;
    op_q.push_back(op);
  endfunction

  // register write: setup cycle, then access cycle until pready
  task automatic cfg_write(input logic [wrp_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [wrp_pkg::APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // writes to any other register index are dropped by the block
    if (addr[2] == wrp_pkg::REG_ENTRIES_IN_USE) cfg_entries = data[wrp_pkg::CFG_W-1:0];
  endtask

  // wait until every beat is taken and every result is in, then let updates finish
  task automatic drain();
    while (op_q.size() != 0 || in_valid || pick_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase(input logic [wrp_pkg::CFG_W-1:0] count, input int unsigned beats);
    cfg_write(ADDR_ENTRIES, wrp_pkg::APB_DATA_W'(count));
    for (int i = 0; i < beats; i++) op_q.push_back(random_op(live_entries()));
    drain();
  endtask

  // input driver: presents queued beats, idles in short bursts, predicts on accept
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) roll_wheel(op_beat);
      // a stalled beat holds; otherwise pick the next action
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && op_q.size() != 0 && $urandom_range(0, 5) == 0) begin
          // short idle burst
          gap_left = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else if (op_q.size() != 0) begin
          op_beat  <= op_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: checks each accepted result and throws stall bursts at the block
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pick_q.size() == 0) begin
          report_mismatch($sformatf("result with no pick pending: entry %0d no_pick %0b",
                                    picked_entry, no_pick));
        end else begin
          pick_t want;
          want = pick_q.pop_front();
          if (picked_entry !== want.entry) begin
            report_mismatch($sformatf("picked_entry %0d, expected %0d",
                                      picked_entry, want.entry));
          end
          if (no_pick !== want.missed) begin
            report_mismatch($sformatf("no_pick %0b, expected %0b", no_pick, want.missed));
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) weight_table[i] = '0;
    weight_sum  = '0;
    cfg_entries = wrp_pkg::CFG_ENTRIES_RESET;

    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;

    // directed: full table, zero total, saturation, scale edges, punch back to zero
    cfg_write(ADDR_ENTRIES, wrp_pkg::APB_DATA_W'(ENTRIES));
    queue_op(wrp_pkg::KIND_PICK,  9'd0,   32'h0000_0000, 16'h0000);  // zero total
    queue_op(wrp_pkg::KIND_PICK,  9'd0,   32'h0000_0000, 16'hFFFF);
    queue_op(wrp_pkg::KIND_ADD,   9'd0,   32'h0001_0000, 16'h0000);
    queue_op(wrp_pkg::KIND_PICK,  9'd0,   32'h0000_0000, 16'h0000);
    queue_op(wrp_pkg::KIND_ADD,   9'd511, 32'hFFFF_FFFF, 16'h0000);
    queue_op(wrp_pkg::KIND_ADD,   9'd511, 32'hFFFF_FFFF, 16'h0000);  // add saturates
    queue_op(wrp_pkg::KIND_PICK,  9'd0,   32'h0000_0000, 16'hFFFF);
    queue_op(wrp_pkg::KIND_PICK,  9'd0,   32'h0000_0000, 16'h0000);
    queue_op(wrp_pkg::KIND_SCALE, 9'd0,   32'h0002_0000, 16'h0000);  // times two
    queue_op(wrp_pkg::KIND_SCALE, 9'd511, 32'hFFFF_FFFF, 16'h0000);  // scale saturates
    queue_op(wrp_pkg::KIND_SCALE, 9'd0,   32'h0000_8000, 16'h0000);  // times one half
    queue_op(wrp_pkg::KIND_SCALE, 9'd1,   32'hFFFF_FFFF, 16'h0000);  // zero weight stays zero
    queue_op(wrp_pkg::KIND_ADD,   9'd255, 32'h5555_AAAA, 16'h0000);
    queue_op(wrp_pkg::KIND_PICK,  9'd0,   32'h0000_0000, 16'h8000);
    queue_op(wrp_pkg::KIND_PUNCH, 9'd511, 32'hFFFF_FFFF, 16'h0000);
    queue_op(wrp_pkg::KIND_PICK,  9'd0,   32'h0000_0000, 16'hFFFF);
    queue_op(wrp_pkg::KIND_SCALE, 9'd255, 32'h0000_0000, 16'h0000);  // scale by zero
    queue_op(wrp_pkg::KIND_PICK,  9'd0,   32'h0000_0000, 16'hAAAA);
    queue_op(wrp_pkg::KIND_PUNCH, 9'd0,   32'h0000_0000, 16'h0000);  // total back to zero
    queue_op(wrp_pkg::KIND_PICK,  9'd0,   32'h0000_0000, 16'h5555);
    queue_op(wrp_pkg::KIND_ADD,   9'd7,   32'h0000_0001, 16'h0000);
    drain();

    // directed: four live entries, entry 7 keeps weight outside the scan
    cfg_write(ADDR_ENTRIES, 32'd4);
    queue_op(wrp_pkg::KIND_ADD,   9'd300, 32'h1234_5678, 16'h0000);  // out of range, dropped
    queue_op(wrp_pkg::KIND_SCALE, 9'd7,   32'h0002_0000, 16'h0000);  // out of range, dropped
    queue_op(wrp_pkg::KIND_PUNCH, 9'd4,   32'h0000_0000, 16'h0000);  // out of range, dropped
    queue_op(wrp_pkg::KIND_ADD,   9'd3,   32'h0000_0010, 16'h0000);
    queue_op(wrp_pkg::KIND_PICK,  9'd0,   32'h0000_0000, 16'h0000);
    queue_op(wrp_pkg::KIND_PICK,  9'd0,   32'h0000_0000, 16'hFFFF);  // scan overshoots
    drain();

    // write to an unused register index must not touch the entry count
    cfg_write(ADDR_SPARE, 32'h0000_0003);

    // random phases: mostly small counts, a few full scans and the extremes
    random_phase(10'd8,    200);
    random_phase(10'd1,     60);
    random_phase(10'd32,   200);
    random_phase(10'd512,   80);
    random_phase(10'd0,     30);
    random_phase(10'd1023,  60);
    random_phase(10'd3,    150);
    random_phase(10'd16,   150);
    random_phase(10'd200,   80);
    calm = 1'b1;
    random_phase(10'd64,   150);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/wrp_pkg.sv
hw/rtl/wrp_ctrl.sv
hw/rtl/wrp_datapath.sv
hw/rtl/weighted_random_picker_unit.sv
verif/tb_weighted_random_picker_unit.sv
